[design/sts_pkg.sv]
// sts_pkg: shared constants, codes, command/status structs and the quarter-wave sine table
// for the sine tone synthesizer. No dependencies.
// the table is built at elaboration by an integer taylor series

package sts_pkg;

    // table geometry (table length is a power of two)
    localparam int TABLE_BITS = 10;
    localparam int TABLE_LEN  = 1 << TABLE_BITS;
    localparam int QBITS      = TABLE_BITS - 2;
    localparam int QUARTER    = TABLE_LEN / 4;

    // field widths fixed by the item format
    localparam int FREQ_W   = 18;
    localparam int RATE_W   = 18;
    localparam int COUNT_W  = 7;
    localparam int MAG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int ABS_W    = 15;
    localparam int PROD_W   = ABS_W + MAG_W;

    // run length limit
    localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(64);

    // divider: one quotient bit per half step, two per cycle
    localparam int DIV_BITS  = FREQ_W + PHASE_W;
    localparam int DIV_STEPS = DIV_BITS / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // rounding offset for the table index, half a table slot in phase units
    localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(1) << (PHASE_W - 1 - TABLE_BITS);

    // magnitude of unity in q1.15
    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(32768);

    // item kinds
    localparam logic KIND_TONE  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b1;

    // register reset values
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    // controller to datapath commands
    typedef struct packed {
        logic clr_phase;
        logic zero_step;
        logic div_start;
        logic issue;
        logic last;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic adv;
        logic div_done;
        logic rate_zero;
    } t_sts;

    // quarter-wave table, entries 0..QUARTER inclusive
    typedef logic [QUARTER:0][ABS_W-1:0] t_qtab;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    // sin(x) in q30 for x in q30 within [0, pi/2]
    function automatic longint sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        // alternating terms x^3/3! up to x^13/13!
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        return sum;
    endfunction

    // magnitude of one first-half-turn entry
    function automatic logic [ABS_W-1:0] quarter_entry(input int j);
        longint unsigned jj;
        longint unsigned p;
        longint unsigned q;
        longint unsigned r;
        longint          s;
        longint          v;
        jj = 64'(j);
        p  = jj << (32 - TABLE_BITS);
        q  = (p >> 30) & 64'd3;
        r  = p & (Q30_ONE - 64'd1);
        if ((q & 64'd1) != 64'd0) begin
            r = Q30_ONE - r;
        end
        s = sin_q30((r * HALF_PI_Q30) >> 30);
        if (s < 0) begin
            s = 0;
        end
        v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return ABS_W'(v);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        int    j;
        for (j = 0; j <= QUARTER; j++) begin
            t[j] = quarter_entry(j);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

endpackage

[design/sts_if.sv]
// sts_if: valid/ready channel interfaces for the sine tone synthesizer
// (input items, result items, configuration writes). Depends on sts_pkg.

// input item channel
interface sts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [sts_pkg::FREQ_W-1:0]   tone_freq_hz;
    logic [sts_pkg::COUNT_W-1:0]  sample_count;

    modport source (output valid, kind, tone_freq_hz, sample_count, input ready);
    modport sink   (input valid, kind, tone_freq_hz, sample_count, output ready);
endinterface

// result item channel
interface sts_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sts_pkg::SAMPLE_W-1:0] sample;
    logic                                last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

// configuration write channel
interface sts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sts_pkg::CFG_IDX_W-1:0]  index;
    logic [sts_pkg::RATE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/sts_div.sv]
// sts_div: serial divider giving the low 32 bits of (freq << 32) / rate,
// two restoring steps per cycle. Depends on sts_pkg.

module sts_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sts_pkg::FREQ_W-1:0]    i_freq,
    input  logic [sts_pkg::RATE_W-1:0]    i_rate,
    output logic                          o_done,
    output logic [sts_pkg::PHASE_W-1:0]   o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [sts_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [sts_pkg::RATE_W-1:0]      r_rem;
    logic [sts_pkg::FREQ_W-1:0]      r_dvd;
    logic [sts_pkg::PHASE_W-1:0]     r_quo;

    logic [sts_pkg::RATE_W:0]        w_t1;
    logic [sts_pkg::RATE_W:0]        w_t2;
    logic                            w_ge1;
    logic                            w_ge2;
    logic [sts_pkg::RATE_W-1:0]      w_rem1;
    logic [sts_pkg::RATE_W-1:0]      w_rem2;

    // two dependent restoring steps
    always_comb begin
        w_t1   = {r_rem, r_dvd[sts_pkg::FREQ_W-1]};
        w_ge1  = w_t1 >= {1'b0, i_rate};
        w_rem1 = w_ge1 ? sts_pkg::RATE_W'(w_t1 - {1'b0, i_rate})
                       : w_t1[sts_pkg::RATE_W-1:0];
        w_t2   = {w_rem1, r_dvd[sts_pkg::FREQ_W-2]};
        w_ge2  = w_t2 >= {1'b0, i_rate};
        w_rem2 = w_ge2 ? sts_pkg::RATE_W'(w_t2 - {1'b0, i_rate})
                       : w_t2[sts_pkg::RATE_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == sts_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sts_pkg::DIV_CNT_W'(sts_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - sts_pkg::DIV_CNT_W'(1);
                if (r_cnt == sts_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder, dividend bits and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_freq;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_dvd <= {r_dvd[sts_pkg::FREQ_W-3:0], 2'b00};
            r_quo <= {r_quo[sts_pkg::PHASE_W-3:0], w_ge1, w_ge2};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[design/sts_ctrl.sv]
// sts_ctrl: controller state machine for the sine tone synthesizer; takes input items
// and sequences division and the sample run. Depends on sts_pkg and sts_if.

module sts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sts_in_if.sink           i_in,
    input  sts_pkg::t_sts    i_sts,
    output sts_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN
    } t_state;

    t_state                         r_state;
    logic [sts_pkg::COUNT_W-1:0]    r_left;

    logic                           w_accept;
    logic                           w_tone;
    logic                           w_freq_zero;
    logic [sts_pkg::COUNT_W-1:0]    w_count;

    // decode the offered item
    always_comb begin
        w_accept    = i_in.valid && i_in.ready;
        w_tone      = i_in.kind == sts_pkg::KIND_TONE;
        w_freq_zero = i_in.tone_freq_hz == '0;
        w_count     = (i_in.sample_count > sts_pkg::MAX_RUN) ? sts_pkg::MAX_RUN
                                                              : i_in.sample_count;
    end

    assign i_in.ready = r_state == S_IDLE;

    // commands to the datapath
    always_comb begin
        o_cmd.clr_phase = w_accept && (!w_tone || w_freq_zero);
        o_cmd.zero_step = w_accept && w_tone && (w_freq_zero || i_sts.rate_zero);
        o_cmd.div_start = w_accept && w_tone && !w_freq_zero && !i_sts.rate_zero
                          && (w_count != '0);
        o_cmd.issue     = (r_state == S_RUN) && i_sts.adv;
        o_cmd.last      = r_left == sts_pkg::COUNT_W'(1);
    end

    // state and remaining sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_tone && (w_count != '0)) begin
                        r_left <= w_count;
                        if (!w_freq_zero && !i_sts.rate_zero) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_sts.adv) begin
                        r_left <= r_left - sts_pkg::COUNT_W'(1);
                        if (r_left == sts_pkg::COUNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/sts_dpath.sv]
// sts_dpath: datapath of the sine tone synthesizer; configuration registers, phase
// accumulator, divider, table lookup, scaling pipeline and output register.
// Depends on sts_pkg, sts_if and sts_div.

module sts_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sts_cfg_if.sink                       i_cfg,
    input  logic [sts_pkg::FREQ_W-1:0]    i_tone_freq_hz,
    input  sts_pkg::t_cmd                 i_cmd,
    output sts_pkg::t_sts                 o_sts,
    sts_out_if.source                     o_out
);

    logic [sts_pkg::MAG_W-1:0]       r_mag;
    logic [sts_pkg::RATE_W-1:0]      r_rate;
    logic [sts_pkg::PHASE_W-1:0]     r_phase;
    logic [sts_pkg::PHASE_W-1:0]     r_step;

    logic                            r_s1_valid;
    logic                            r_s1_last;
    logic                            r_s1_neg;
    logic [sts_pkg::ABS_W-1:0]       r_s1_abs;

    logic                            r_s2_valid;
    logic                            r_s2_last;
    logic                            r_s2_neg;
    logic [sts_pkg::PROD_W-1:0]      r_s2_prod;

    logic                            r_o_valid;
    logic                            r_o_last;
    logic [sts_pkg::SAMPLE_W-1:0]    r_o_sample;

    logic                            w_adv;
    logic                            w_div_done;
    logic [sts_pkg::PHASE_W-1:0]     w_quot;
    logic [sts_pkg::PHASE_W-1:0]     w_rphase;
    logic [sts_pkg::TABLE_BITS-1:0]  w_idx;
    logic [1:0]                      w_quad;
    logic [sts_pkg::QBITS-1:0]       w_low;
    logic [sts_pkg::QBITS:0]         w_fold;
    logic [sts_pkg::PHASE_W-1:0]     w_sum;
    logic [sts_pkg::SAMPLE_W-1:0]    w_round;

    // phase step divider
    sts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_freq  (i_tone_freq_hz),
        .i_rate  (r_rate),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // configuration registers, magnitude clamped to unity on write
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag  <= sts_pkg::MAG_ONE;
            r_rate <= sts_pkg::RATE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sts_pkg::CFG_MAGNITUDE: begin
                    r_mag <= (i_cfg.data[sts_pkg::MAG_W-1:0] > sts_pkg::MAG_ONE)
                             ? sts_pkg::MAG_ONE : i_cfg.data[sts_pkg::MAG_W-1:0];
                end
                sts_pkg::CFG_SAMPLE_RATE: begin
                    r_rate <= i_cfg.data;
                end
                default: begin
                    r_rate <= r_rate;
                end
            endcase
        end
    end

    // pipeline moves whenever the output register is free or being taken
    assign w_adv = !r_o_valid || o_out.ready;

    always_comb begin
        o_sts.adv       = w_adv;
        o_sts.div_done  = w_div_done;
        o_sts.rate_zero = r_rate == '0;
    end

    // phase accumulator and step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.clr_phase) begin
            r_phase <= '0;
        end else if (i_cmd.issue) begin
            r_phase <= r_phase + r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_step) begin
            r_step <= '0;
        end else if (w_div_done) begin
            r_step <= w_quot;
        end
    end

    // rounded table index and quarter-wave fold
    always_comb begin
        w_rphase = r_phase + sts_pkg::PHASE_HALF;
        w_idx    = w_rphase[sts_pkg::PHASE_W-1 -: sts_pkg::TABLE_BITS];
        w_quad   = w_idx[sts_pkg::TABLE_BITS-1 -: 2];
        w_low    = w_idx[sts_pkg::QBITS-1:0];
        w_fold   = w_quad[0] ? ((sts_pkg::QBITS+1)'(sts_pkg::QUARTER) - {1'b0, w_low})
                             : {1'b0, w_low};
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    // rounding of the scaled magnitude
    always_comb begin
        w_sum   = sts_pkg::PHASE_W'(r_s2_prod) + sts_pkg::PHASE_W'(16384);
        w_round = w_sum[sts_pkg::SAMPLE_W+14:15];
    end

    // table read, multiply, round and sign
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last  <= i_cmd.last;
            r_s1_neg   <= w_quad[1];
            r_s1_abs   <= sts_pkg::QTAB[w_fold];
            r_s2_last  <= r_s1_last;
            r_s2_neg   <= r_s1_neg;
            r_s2_prod  <= sts_pkg::PROD_W'(r_s1_abs) * sts_pkg::PROD_W'(r_mag);
            r_o_last   <= r_s2_last;
            r_o_sample <= r_s2_neg ? (sts_pkg::SAMPLE_W'(0) - w_round) : w_round;
        end
    end

    assign o_out.valid  = r_o_valid;
    assign o_out.last   = r_o_last;
    assign o_out.sample = r_o_sample;

endmodule

[design/sine_tone_synthesizer.sv]
// sine_tone_synthesizer: top level of the phase-continuous sine tone generator.
// Depends on sts_pkg, sts_if, sts_ctrl and sts_dpath (which holds sts_div).

// A generate item (kind 0) is accepted while the block is idle, then the phase step is
// worked out in the serial divider (two quotient bits a cycle over 50 bits) and the
// finished step is loaded. Then one sample a cycle, while the output is not stalled, for
// sample_count samples (at most 64); the next item is taken once the last sample has
// entered the three-stage lookup and scaling pipeline. A zero frequency or a zero
// sample rate skips the divider, and a reset item (kind 1) or a zero-length run is
// taken without starting a run. Samples leave through an output register, so output
// stalls hold the pipeline and the issue of new samples. Configuration writes are
// always ready and are meant to arrive while no run is in progress.

module sine_tone_synthesizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sts_in_if.sink      i_in,
    sts_out_if.source   o_out,
    sts_cfg_if.sink     i_cfg
);

    sts_pkg::t_cmd w_cmd;
    sts_pkg::t_sts w_sts;

    // controller
    sts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath
    sts_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (i_cfg),
        .i_tone_freq_hz (i_in.tone_freq_hz),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out          (o_out)
    );

endmodule

[tb/tone_checker.sv]
// tone_checker: watches the item, result and register channels of the sine tone synthesizer,
// predicts every tone sample from its own phase accumulator and sine table, and compares.
// Depends on sts_pkg and the channel interfaces in sts_if.

module tone_checker
    import sts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sts_in_if    i_item_mon,
    sts_out_if   i_res_mon,
    sts_cfg_if   i_cfg_mon,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_checked
);

    // pi/2 in q30, used to map a quarter turn onto radians
    localparam longint unsigned QTURN_RAD_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30       = 64'd1 << 30;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } tone_sample_t;

    tone_sample_t               expected_samples[$];
    tone_sample_t               want;
    logic signed [SAMPLE_W-1:0] sine_lut [TABLE_LEN];
    logic [PHASE_W-1:0]         phase_model;
    logic [MAG_W-1:0]           mag_reg;
    logic [RATE_W-1:0]          rate_reg;
    int                         fails;
    int                         checked;

    // sine of a q30 angle in [0, pi/2] by a taylor series up to x^13
    function automatic longint taylor_sin_q30(input longint unsigned x);
        longint unsigned xsq;
        longint unsigned term;
        longint          acc;
        int              k;
        xsq  = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 6; k++) begin
            term = ((term * xsq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // one full-wave table entry, q1.15, folded from the first quadrant
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int i);
        longint unsigned frac;
        longint          s;
        longint          v;
        int              quad;
        quad = (i >> (TABLE_BITS - 2)) & 3;
        frac = longint'(i % QUARTER) << (30 - (TABLE_BITS - 2));
        if (quad % 2 == 1) begin
            frac = ONE_Q30 - frac;
        end
        s = taylor_sin_q30((frac * QTURN_RAD_Q30) >> 30);
        if (s < 0) begin
            s = 0;
        end
        v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        if (quad >= 2) begin
            v = -v;
        end
        return SAMPLE_W'(v);
    endfunction

    initial begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            sine_lut[i] = sine_entry(i);
        end
    end

    // count a failure and report it
    task automatic note_failure(input string msg);
        $display("%0t: %s", $time, msg);
        fails++;
    endtask

    // work out the samples of one accepted item and advance or clear the phase
    task automatic predict_tone_run(input logic kind, input logic [FREQ_W-1:0] freq,
                                    input logic [COUNT_W-1:0] count);
        logic [PHASE_W-1:0]         step;
        logic [PHASE_W-1:0]         p;
        logic [63:0]                lookup;
        logic [TABLE_BITS-1:0]      idx;
        logic signed [SAMPLE_W-1:0] v;
        logic [31:0]                a;
        logic [31:0]                scaled;
        logic [MAG_W-1:0]           mag;
        int                         n;
        tone_sample_t               s;
        if (kind == KIND_RESET) begin
            phase_model = '0;
        end else begin
            n   = (count > MAX_RUN) ? int'(MAX_RUN) : int'(count);
            mag = (mag_reg > MAG_ONE) ? MAG_ONE : mag_reg;
            if (freq == '0) begin
                // silence, phase cleared
                for (int k = 0; k < n; k++) begin
                    s.sample = '0;
                    s.last   = (k == n - 1);
                    expected_samples.push_back(s);
                end
                phase_model = '0;
            end else begin
                step = '0;
                if (rate_reg != '0) begin
                    step = PHASE_W'({14'd0, freq, 32'd0} / {46'd0, rate_reg});
                end
                for (int k = 0; k < n; k++) begin
                    p      = phase_model + PHASE_W'(k) * step;
                    lookup = ({32'd0, p} << TABLE_BITS) + (64'd1 << 31);
                    idx    = lookup[PHASE_W +: TABLE_BITS];
                    v      = sine_lut[idx];
                    a      = (v < 0) ? 32'(-int'(v)) : 32'(int'(v));
                    scaled = (a * 32'(mag) + 32'd16384) >> 15;
                    s.sample = (v < 0) ? -scaled[SAMPLE_W-1:0] : scaled[SAMPLE_W-1:0];
                    s.last   = (k == n - 1);
                    expected_samples.push_back(s);
                end
                phase_model = phase_model + PHASE_W'(n) * step;
            end
        end
    endtask

    // monitor all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_model = '0;
            mag_reg     = MAG_ONE;
            rate_reg    = RATE_RESET;
            expected_samples.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_samples.size() == 0) begin
                    note_failure($sformatf("unexpected sample: expected none, got %0d last %0b",
                                           i_res_mon.sample, i_res_mon.last));
                end else begin
                    want = expected_samples.pop_front();
                    checked++;
                    if (i_res_mon.sample !== want.sample) begin
                        note_failure($sformatf("sample mismatch: expected %0d, got %0d",
                                               want.sample, i_res_mon.sample));
                    end
                    if (i_res_mon.last !== want.last) begin
                        note_failure($sformatf("last mismatch: expected %0b, got %0b",
                                               want.last, i_res_mon.last));
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                if (i_cfg_mon.index == CFG_MAGNITUDE) begin
                    mag_reg = i_cfg_mon.data[MAG_W-1:0];
                end else begin
                    rate_reg = i_cfg_mon.data;
                end
            end
            if (i_item_mon.valid && i_item_mon.ready) begin
                predict_tone_run(i_item_mon.kind, i_item_mon.tone_freq_hz,
                                 i_item_mon.sample_count);
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= expected_samples.size();
        o_checked  <= checked;
    end

endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for the sine tone synthesizer; directed tone runs, then
// random phases with bursty items, output stalls and register changes between phases.
// Depends on sts_pkg, sts_if, the block itself and tone_checker.

module tb_top;
    import sts_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 60;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 39;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sts_in_if  in_ch ();
    sts_out_if out_ch ();
    sts_cfg_if cfg_ch ();

    int chk_fails;
    int chk_pending;
    int chk_checked;

    int unsigned     items_sent;
    int unsigned     reg_writes;
    int unsigned     burst_left;
    bit              no_gaps;
    int unsigned     hold_req;
    int unsigned     hold_done;
    int unsigned     hold_left;
    int unsigned     rx_mode;
    int unsigned     rx_cycle;
    int unsigned     cycle_cnt;
    logic [RATE_W-1:0] cur_rate;

    sine_tone_synthesizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tone_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_mon (in_ch),
        .i_res_mon  (out_ch),
        .i_cfg_mon  (cfg_ch),
        .o_fail_cnt (chk_fails),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d samples outstanding", cycle_cnt, chk_pending);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        rx_cycle++;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_cycle % 97 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (rx_cycle % 8 >= 3);
            endcase
        end
    end

    // offer one item and wait until it is taken, then maybe leave a gap
    task automatic send_item(input logic kind, input logic [FREQ_W-1:0] freq,
                             input logic [COUNT_W-1:0] count);
        int unsigned gap;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.tone_freq_hz <= freq;
        in_ch.sample_count <= count;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 15);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(0, 8);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait until every sample is in and the block has gone quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SAMPLE_RATE) begin
            cur_rate = data;
        end
        reg_writes++;
    endtask

    // mostly tones at sensible rates with short runs, some noise and resets
    task automatic send_random_item();
        int unsigned        pick;
        int unsigned        top_freq;
        logic [FREQ_W-1:0]  f;
        logic [COUNT_W-1:0] n;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            send_item(KIND_RESET, FREQ_W'($urandom), COUNT_W'($urandom));
        end else begin
            top_freq = (cur_rate > 3) ? cur_rate / 2 : 1;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                f = '0;
            end else if (pick < 70) begin
                f = FREQ_W'($urandom_range(1, top_freq));
            end else begin
                f = FREQ_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n = COUNT_W'($urandom_range(1, 12));
            end else if (pick < 85) begin
                n = COUNT_W'($urandom_range(13, 64));
            end else if (pick < 95) begin
                n = ($urandom_range(0, 1) == 0) ? '0 : MAX_RUN;
            end else begin
                n = COUNT_W'($urandom_range(65, 127));
            end
            send_item(KIND_TONE, f, n);
        end
    endtask

    // register values for one random phase, extremes included
    task automatic pick_config();
        logic [RATE_W-1:0] m;
        logic [RATE_W-1:0] r;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = RATE_W'(MAG_ONE);
            2: m = RATE_W'(16'hFFFF);
            3: m = RATE_W'($urandom_range(1, 32767));
            4: m = RATE_W'($urandom);
            default: m = RATE_W'($urandom_range(32769, 65535));
        endcase
        case ($urandom_range(0, 5))
            0: r = RATE_W'(1);
            1: r = '1;
            2: r = RATE_RESET;
            3: r = RATE_W'($urandom_range(1000, 96000));
            4: r = RATE_W'($urandom_range(1, 262143));
            default: r = RATE_W'($urandom_range(100, 2000));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_MAGNITUDE, m);
            write_reg(CFG_SAMPLE_RATE, r);
        end else begin
            write_reg(CFG_SAMPLE_RATE, r);
            write_reg(CFG_MAGNITUDE, m);
        end
    endtask

    // main stimulus
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_TONE;
        in_ch.tone_freq_hz = '0;
        in_ch.sample_count = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_MAGNITUDE;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        items_sent = 0;
        reg_writes = 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        hold_req   = 0;
        hold_done  = 0;
        hold_left  = 0;
        rx_mode    = 0;
        rx_cycle   = 0;
        cur_rate   = RATE_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: continuity, ignored reset fields, overflowing step, silence,
        // empty run, over-long run, nyquist
        send_item(KIND_TONE, 18'd1000, 7'd8);
        send_item(KIND_TONE, 18'd1000, 7'd1);
        send_item(KIND_RESET, '1, '1);
        send_item(KIND_TONE, '1, MAX_RUN);
        send_item(KIND_TONE, '0, 7'd5);
        send_item(KIND_TONE, 18'd12345, '0);
        send_item(KIND_TONE, 18'd1, '1);
        send_item(KIND_TONE, 18'd24000, 7'd3);
        send_item(KIND_TONE, '0, '0);
        send_item(KIND_TONE, 18'd100, 7'd65);

        // magnitude above one, slowest rate (step wraps to nothing)
        settle();
        write_reg(CFG_MAGNITUDE, '1);
        write_reg(CFG_SAMPLE_RATE, RATE_W'(1));
        send_item(KIND_TONE, 18'd3, 7'd4);
        send_item(KIND_TONE, '0, 7'd2);

        // muted output at the fastest rate
        settle();
        write_reg(CFG_MAGNITUDE, '0);
        write_reg(CFG_SAMPLE_RATE, '1);
        send_item(KIND_TONE, '1, 7'd4);
        send_item(KIND_TONE, 18'd131071, 7'd4);
        send_item(KIND_TONE, 18'd65536, 7'd4);

        // zero sample rate holds the phase, smallest magnitude
        settle();
        write_reg(CFG_MAGNITUDE, RATE_W'(1));
        write_reg(CFG_SAMPLE_RATE, '0);
        send_item(KIND_TONE, 18'd5000, 7'd4);
        send_item(KIND_TONE, '1, 7'd2);

        // quarter-turn steps hit the peaks and zero crossings
        settle();
        write_reg(CFG_MAGNITUDE, RATE_W'(32767));
        write_reg(CFG_SAMPLE_RATE, RATE_W'(4));
        send_item(KIND_TONE, 18'd1, 7'd8);
        send_item(KIND_TONE, 18'd2, 7'd6);

        // random phases
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            pick_config();
            for (int it = 0; it < PHASE_ITEMS; it++) begin
                if (ph == 2 && it == 5) begin
                    // long output hold while items keep coming
                    hold_req++;
                    no_gaps = 1'b1;
                    repeat (8) send_item(KIND_TONE, FREQ_W'($urandom_range(1, 20000)), MAX_RUN);
                    no_gaps = 1'b0;
                end else if (ph == 5 && it == 20) begin
                    settle();
                end
                send_random_item();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d items over %0d register settings, %0d samples compared",
                 items_sent, reg_writes, chk_checked);
        $display("including silent, empty, over-long and wrapping runs and long output stalls");
        if (chk_fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", chk_fails);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sine_tone_synthesizer.f]
design/sts_pkg.sv
design/sts_if.sv
design/sts_div.sv
design/sts_ctrl.sv
design/sts_dpath.sv
design/sine_tone_synthesizer.sv
tb/tone_checker.sv
tb/tb_top.sv
